>>> rtl/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg: shared types and constants for the LRU line cache
// Register indexes, field widths, reset values and the request/status
// structs passed between the top level and the tag array.
// ----------------------------------------------------------------------------
package lrc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LINES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_LATENCY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_LATENCY = 2'd2;

    // field widths
    localparam int ACTIVE_W  = 8;
    localparam int HIT_LAT_W = 8;
    localparam int LAT_W     = 10;
    localparam int EVLINE_W  = 26;
    localparam int CNT_W     = 32;

    // register reset values
    localparam logic [ACTIVE_W-1:0]  ACTIVE_LINES_RST = 8'd128;
    localparam logic [HIT_LAT_W-1:0] HIT_LATENCY_RST  = 8'd2;
    localparam logic [LAT_W-1:0]     MISS_LATENCY_RST = 10'd100;

    // access request into the tag array
    typedef struct packed {
        logic                access;
        logic [ACTIVE_W-1:0] active_lines;
    } lrc_req_t;

    // lookup outcome from the tag array
    typedef struct packed {
        logic hit;
        logic evict;
    } lrc_lookup_t;

endpackage

>>> rtl/lrc_tag_array.sv
// ----------------------------------------------------------------------------
// lrc_tag_array: fully associative tag store with rank-based LRU
// Parallel tag compare, LRU pick and rank update for one access per cycle.
// Lines fill slots in index order and are never freed, so the next free
// slot is always the one at index == occupancy.
// ----------------------------------------------------------------------------
module lrc_tag_array #(
    parameter int NUM_LINES = 128,
    parameter int TAG_W     = 26
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrc_pkg::lrc_req_t    req,
    input  logic [TAG_W-1:0]     tag,
    output lrc_pkg::lrc_lookup_t status,
    output logic [TAG_W-1:0]     evict_tag
);
    import lrc_pkg::*;

    localparam int RANK_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int OCC_W  = $clog2(NUM_LINES + 1);
    localparam int CAP_W  = ((OCC_W > ACTIVE_W) ? OCC_W : ACTIVE_W) + 1;

    logic [TAG_W-1:0]  tags_reg  [NUM_LINES];
    logic [RANK_W-1:0] rank_reg  [NUM_LINES];
    logic [RANK_W-1:0] rank_next [NUM_LINES];
    logic [NUM_LINES-1:0] valid_reg, valid_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;

    logic [NUM_LINES-1:0] match, lru, sel, age;
    logic [RANK_W-1:0] hit_rank;
    logic [TAG_W-1:0]  lru_tag;
    logic [CAP_W-1:0]  cap, active_ext, occ_ext;
    logic [OCC_W-1:0]  limit;
    logic              hit_any, fill, evict;

    // clamp capacity to [1, NUM_LINES]
    always_comb
    begin
        active_ext = CAP_W'(req.active_lines);
        occ_ext    = CAP_W'(occ_reg);
        if (active_ext == '0)
        begin
            cap = CAP_W'(1);
        end
        else if (active_ext > CAP_W'(NUM_LINES))
        begin
            cap = CAP_W'(NUM_LINES);
        end
        else
        begin
            cap = active_ext;
        end
    end

    // parallel compare; at most one entry matches
    always_comb
    begin
        hit_rank = '0;
        lru_tag  = '0;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            match[i] = valid_reg[i] && (tags_reg[i] == tag);
            // LRU entry holds rank occupancy-1
            lru[i]   = valid_reg[i] && (OCC_W'(rank_reg[i]) == occ_reg - OCC_W'(1));
            hit_rank = hit_rank | (match[i] ? rank_reg[i] : '0);
            lru_tag  = lru_tag  | (lru[i]   ? tags_reg[i] : '0);
        end
    end

    assign hit_any = |match;
    assign fill    = !hit_any && (occ_ext < cap);
    assign evict   = !hit_any && !fill;

    assign status.hit   = hit_any;
    assign status.evict = evict;
    assign evict_tag    = lru_tag;

    // entries more recent than the limit age by one
    always_comb
    begin
        if (hit_any)
        begin
            limit = OCC_W'(hit_rank);
        end
        else if (fill)
        begin
            limit = occ_reg;
        end
        else
        begin
            limit = occ_reg - OCC_W'(1);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            sel[i] = hit_any ? match[i] :
                     fill    ? (occ_reg == OCC_W'(i)) : lru[i];
            age[i] = valid_reg[i] && !sel[i] && (OCC_W'(rank_reg[i]) < limit);
            if (sel[i])
            begin
                rank_next[i] = '0;
            end
            else if (age[i])
            begin
                rank_next[i] = rank_reg[i] + RANK_W'(1);
            end
            else
            begin
                rank_next[i] = rank_reg[i];
            end
            if (fill && sel[i])
            begin
                valid_next[i] = 1'b1;
            end
        end
        if (fill)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (req.access)
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // tag storage, undefined until written
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_LINES; i++)
        begin
            if (req.access && !hit_any && sel[i])
            begin
                tags_reg[i] <= tag;
            end
        end
    end

endmodule

>>> rtl/lru_line_cache_model.sv
// ----------------------------------------------------------------------------
// lru_line_cache_model: fully associative LRU line cache tag store
// Byte addresses map to line numbers; each access reports hit, latency,
// eviction and saturating hit/miss totals.
// ----------------------------------------------------------------------------
//
//  channel   handshake               words
//  -------   ---------------------   ------------------------------------------
//  command   start & !busy           address
//  result    done (one-cycle pulse)  hit, latency, evicted, evicted_line,
//                                    hit_count, miss_count
//  config    cfg_valid & cfg_ready   cfg_index, cfg_data
//
//  One access per clock. done follows start through the input register
//  and then, through the tag array lookup/update, the result register.
//  The compare and rank update over all lines are combinational between
//  those two registers. busy and cfg_ready stay low/high.
//  Reset invalidates every line and clears ranks, occupancy and totals at
//  once; there is no clearing pass. The receiver cannot stall results.
//
module lru_line_cache_model #(
    parameter int NUM_LINES  = 128,
    parameter int LINE_BYTES = 64,
    parameter int ADDR_BITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command
    input  logic                              start,
    output logic                              busy,
    input  logic [ADDR_BITS-1:0]              address,
    // result
    output logic                              done,
    output logic                              hit,
    output logic [lrc_pkg::LAT_W-1:0]         latency,
    output logic                              evicted,
    output logic [lrc_pkg::EVLINE_W-1:0]      evicted_line,
    output logic [lrc_pkg::CNT_W-1:0]         hit_count,
    output logic [lrc_pkg::CNT_W-1:0]         miss_count,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lrc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lrc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lrc_pkg::*;

    localparam int OFFSET_W = $clog2(LINE_BYTES);
    localparam int TAG_W    = ADDR_BITS - OFFSET_W;

    // input register
    logic             req_valid_reg;
    logic [TAG_W-1:0] tag_reg;

    // configuration registers
    logic [ACTIVE_W-1:0]  active_lines_reg;
    logic [HIT_LAT_W-1:0] hit_latency_reg;
    logic [LAT_W-1:0]     miss_latency_reg;

    // running totals, shown directly on the result ports
    logic [CNT_W-1:0] hit_total_reg, hit_total_next;
    logic [CNT_W-1:0] miss_total_reg, miss_total_next;

    // result register
    logic                done_reg;
    logic                hit_reg;
    logic [LAT_W-1:0]    latency_reg, latency_next;
    logic                evicted_reg;
    logic [EVLINE_W-1:0] evicted_line_reg, evicted_line_next;

    lrc_req_t         req;
    lrc_lookup_t      status;
    logic [TAG_W-1:0] evict_tag;
    logic [TAG_W+EVLINE_W-1:0] evict_tag_ext;

    // lookup and update are combinational in the tag array: the command port never blocks
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign req.access       = req_valid_reg;
    assign req.active_lines = active_lines_reg;

    lrc_tag_array #(
        .NUM_LINES (NUM_LINES),
        .TAG_W     (TAG_W)
    ) u_tag_array (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .tag       (tag_reg),
        .status    (status),
        .evict_tag (evict_tag)
    );

    // evicted line reported at a fixed 26 bits whatever the tag width
    assign evict_tag_ext = {{EVLINE_W{1'b0}}, evict_tag};

    always_comb
    begin
        latency_next      = status.hit ? LAT_W'(hit_latency_reg) : miss_latency_reg;
        evicted_line_next = status.evict ? evict_tag_ext[EVLINE_W-1:0] : '0;
        hit_total_next    = hit_total_reg;
        miss_total_next   = miss_total_reg;
        if (req_valid_reg)
        begin
            if (status.hit)
            begin
                if (hit_total_reg != '1)
                begin
                    hit_total_next = hit_total_reg + CNT_W'(1);
                end
            end
            else if (miss_total_reg != '1)
            begin
                miss_total_next = miss_total_reg + CNT_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg    <= 1'b0;
            done_reg         <= 1'b0;
            hit_total_reg    <= '0;
            miss_total_reg   <= '0;
            active_lines_reg <= ACTIVE_LINES_RST;
            hit_latency_reg  <= HIT_LATENCY_RST;
            miss_latency_reg <= MISS_LATENCY_RST;
        end
        else
        begin
            req_valid_reg  <= start && !busy;
            done_reg       <= req_valid_reg;
            hit_total_reg  <= hit_total_next;
            miss_total_reg <= miss_total_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ACTIVE_LINES: active_lines_reg <= cfg_data[ACTIVE_W-1:0];
                    REG_HIT_LATENCY:  hit_latency_reg  <= cfg_data[HIT_LAT_W-1:0];
                    REG_MISS_LATENCY: miss_latency_reg <= cfg_data[LAT_W-1:0];
                    default:          ; // unmapped index: dropped
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            tag_reg <= address[ADDR_BITS-1:OFFSET_W];
        end
        if (req_valid_reg)
        begin
            hit_reg          <= status.hit;
            latency_reg      <= latency_next;
            evicted_reg      <= status.evict;
            evicted_line_reg <= evicted_line_next;
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign latency      = latency_reg;
    assign evicted      = evicted_reg;
    assign evicted_line = evicted_line_reg;
    assign hit_count    = hit_total_reg;
    assign miss_count   = miss_total_reg;

    // a hit never evicts
    a_hit_no_evict : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && evicted))
        else $error("hit reported together with eviction");

    // totals move only with a delivered result
    a_totals_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !done |=> $stable(hit_count) && $stable(miss_count) || done)
        else $error("totals changed without a result");

    // the total matching the outcome has been counted
    a_total_counted : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hit ? (hit_count != '0) : (miss_count != '0)))
        else $error("result outcome not reflected in totals");

endmodule
